### rtl/plng_pkg.sv
package plng_pkg;

   // defaults for the top-level parameters
   localparam int MAX_DIMS_DEFAULT    = 4;
   localparam int EXTENT_BITS_DEFAULT = 8;

   // fixed field widths
   localparam int FLAT_W      = 32;
   localparam int DIM_FIELD_W = 2;
   localparam int NUM_DIMS_W  = 3;
   localparam int EXT_REG_W   = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_USER_W  = 4;

   // dimensions that have an extent register; the rest have extent one
   localparam int NUM_EXT_REGS = 4;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_D0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_D1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_D2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_D3 = 3'd4;

   // register reset values
   localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RESET = 3'd2;
   localparam logic [EXT_REG_W-1:0]  EXT_RESET [NUM_EXT_REGS] = '{
      9'd16, 9'd16, 9'd1, 9'd1
   };

   // neighbour direction codes
   localparam logic DIR_PLUS  = 1'b0;
   localparam logic DIR_MINUS = 1'b1;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_PASS,
      FRONT_FINISH,
      FRONT_EMIT,
      FRONT_ADVANCE
   } front_state_type;

   // one dimension's worth of work: both neighbours of the current site
   typedef struct packed {
      logic [FLAT_W-1:0]      nb_plus;
      logic [FLAT_W-1:0]      nb_minus;
      logic [FLAT_W-1:0]      site;
      logic [DIM_FIELD_W-1:0] dim;
      logic                   last_dim;
      logic                   last_site;
   } entry_type;

endpackage

### rtl/plng_front.sv
module plng_front #(
   parameter int MAX_DIMS    = plng_pkg::MAX_DIMS_DEFAULT,
   parameter int EXTENT_BITS = plng_pkg::EXTENT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [plng_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plng_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plng_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                q_push,
   output plng_pkg::entry_type                 q_entry,
   input  logic                                q_full
);

   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W = $clog2(MAX_DIMS + 1);
   localparam int EXT_W = EXTENT_BITS + 1;
   localparam logic [31:0] EXT_CAP = 32'(1) << EXTENT_BITS;
   localparam int FW = plng_pkg::FLAT_W;

   plng_pkg::front_state_type state_ff, state_in;

   logic [plng_pkg::NUM_DIMS_W-1:0] num_dims_ff;
   logic [plng_pkg::EXT_REG_W-1:0]  ext_reg_ff [plng_pkg::NUM_EXT_REGS];

   logic [EXTENT_BITS-1:0] coord_ff [MAX_DIMS];
   logic [FW-1:0]          stride_ff [MAX_DIMS];
   logic [FW-1:0]          span_ff [MAX_DIMS];
   logic [DIM_W-1:0]       idx_ff;
   logic [FW-1:0]          run_ff;
   logic [FW-1:0]          acc_ff;
   logic [FW-1:0]          prodc_ff;
   logic [FW-1:0]          prev_stride_ff;
   logic                   first_ff;
   logic                   last_site_ff;

   logic [CNT_W-1:0]       n_dims;
   logic [EXT_W-1:0]       ext [MAX_DIMS];
   logic [EXTENT_BITS-1:0] clean [MAX_DIMS];
   logic [EXTENT_BITS-1:0] adv [MAX_DIMS];
   logic                   last_site_calc;
   logic [EXTENT_BITS-1:0] c_sel;
   logic [EXT_W-1:0]       e_sel;
   logic [FW-1:0]          stride_sel;
   logic [FW-1:0]          span_sel;
   logic [FW-1:0]          nb_plus;
   logic [FW-1:0]          nb_minus;
   logic                   last_emit;
   logic                   req_accept;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= plng_pkg::NUM_DIMS_RESET;
         for (int i = 0; i < plng_pkg::NUM_EXT_REGS; i++) begin
            ext_reg_ff[i] <= plng_pkg::EXT_RESET[i];
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            plng_pkg::CSR_NUM_DIMS: begin
               num_dims_ff <= csr_data[plng_pkg::NUM_DIMS_W-1:0];
            end
            plng_pkg::CSR_EXTENT_D0: ext_reg_ff[0] <= csr_data;
            plng_pkg::CSR_EXTENT_D1: ext_reg_ff[1] <= csr_data;
            plng_pkg::CSR_EXTENT_D2: ext_reg_ff[2] <= csr_data;
            plng_pkg::CSR_EXTENT_D3: ext_reg_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // dimension count clamped to the supported range
   always_comb begin
      if (num_dims_ff == '0) begin
         n_dims = CNT_W'(1);
      end else if (32'(num_dims_ff) > 32'(MAX_DIMS)) begin
         n_dims = CNT_W'(MAX_DIMS);
      end else begin
         n_dims = CNT_W'(num_dims_ff);
      end
   end

   // extents clamped to one .. 2^EXTENT_BITS
   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_ext
      if (g < plng_pkg::NUM_EXT_REGS) begin : g_reg
         always_comb begin
            if (ext_reg_ff[g] == '0) begin
               ext[g] = EXT_W'(1);
            end else if (32'(ext_reg_ff[g]) > EXT_CAP) begin
               ext[g] = EXT_W'(EXT_CAP);
            end else begin
               ext[g] = EXT_W'(ext_reg_ff[g]);
            end
         end
      end else begin : g_one
         assign ext[g] = EXT_W'(1);
      end
   end

   // coordinates as seen by a new transaction, and the last-site flag
   always_comb begin
      last_site_calc = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (req_tdata[0] || d >= int'(n_dims) || EXT_W'(coord_ff[d]) >= ext[d]) begin
            clean[d] = '0;
         end else begin
            clean[d] = coord_ff[d];
         end
         if (d < int'(n_dims) && EXT_W'(clean[d]) != ext[d] - EXT_W'(1)) begin
            last_site_calc = 1'b0;
         end
      end
   end

   // odometer step, last dimension fastest
   always_comb begin
      logic             carry;
      logic [EXT_W-1:0] inc;
      carry = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         inc    = EXT_W'(coord_ff[d]) + EXT_W'(1);
         adv[d] = coord_ff[d];
         if (carry && d < int'(n_dims)) begin
            if (inc >= ext[d]) begin
               adv[d] = '0;
            end else begin
               adv[d] = inc[EXTENT_BITS-1:0];
               carry  = 1'b0;
            end
         end
      end
   end

   // per-dimension selection, shared by the stride pass and emission
   assign c_sel      = coord_ff[idx_ff];
   assign e_sel      = ext[idx_ff];
   assign stride_sel = stride_ff[idx_ff];
   assign span_sel   = span_ff[idx_ff];
   assign last_emit  = CNT_W'(idx_ff) == n_dims - CNT_W'(1);

   // wrap moves the index by (extent-1)*stride the other way
   assign nb_plus  = (EXT_W'(c_sel) == e_sel - EXT_W'(1)) ? acc_ff - span_sel
                                                           : acc_ff + stride_sel;
   assign nb_minus = (c_sel == '0) ? acc_ff + span_sel : acc_ff - stride_sel;

   always_comb begin
      q_entry.nb_plus   = nb_plus;
      q_entry.nb_minus  = nb_minus;
      q_entry.site      = acc_ff;
      q_entry.dim       = plng_pkg::DIM_FIELD_W'(idx_ff);
      q_entry.last_dim  = last_emit;
      q_entry.last_site = last_site_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plng_pkg::FRONT_IDLE: begin
            if (req_tvalid) state_in = plng_pkg::FRONT_PASS;
         end
         plng_pkg::FRONT_PASS: begin
            if (idx_ff == '0) state_in = plng_pkg::FRONT_FINISH;
         end
         plng_pkg::FRONT_FINISH: state_in = plng_pkg::FRONT_EMIT;
         plng_pkg::FRONT_EMIT: begin
            if (!q_full && last_emit) state_in = plng_pkg::FRONT_ADVANCE;
         end
         plng_pkg::FRONT_ADVANCE: state_in = plng_pkg::FRONT_IDLE;
         default: state_in = plng_pkg::FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      q_push     = 1'b0;
      unique case (state_ff)
         plng_pkg::FRONT_IDLE: req_tready = 1'b1;
         plng_pkg::FRONT_EMIT: q_push = !q_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plng_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            coord_ff[d] <= '0;
         end
      end else begin
         unique case (state_ff)
            plng_pkg::FRONT_IDLE: begin
               if (req_accept) begin
                  coord_ff       <= clean;
                  last_site_ff   <= last_site_calc;
                  idx_ff         <= DIM_W'(n_dims - CNT_W'(1));
                  run_ff         <= FW'(1);
                  acc_ff         <= '0;
                  prodc_ff       <= '0;
                  prev_stride_ff <= '0;
                  first_ff       <= 1'b1;
               end
            end
            plng_pkg::FRONT_PASS: begin
               // walk from the fastest dimension down, building strides and the site index
               stride_ff[idx_ff] <= run_ff;
               run_ff            <= run_ff * FW'(e_sel);
               prodc_ff          <= run_ff * FW'(c_sel);
               acc_ff            <= acc_ff + prodc_ff;
               prev_stride_ff    <= run_ff;
               first_ff          <= 1'b0;
               if (!first_ff) begin
                  span_ff[idx_ff + DIM_W'(1)] <= run_ff - prev_stride_ff;
               end
               if (idx_ff != '0) begin
                  idx_ff <= idx_ff - DIM_W'(1);
               end
            end
            plng_pkg::FRONT_FINISH: begin
               acc_ff     <= acc_ff + prodc_ff;
               span_ff[0] <= run_ff - prev_stride_ff;
               idx_ff     <= '0;
            end
            plng_pkg::FRONT_EMIT: begin
               if (!q_full && !last_emit) begin
                  idx_ff <= idx_ff + DIM_W'(1);
               end
            end
            plng_pkg::FRONT_ADVANCE: coord_ff <= adv;
            default: ;
         endcase
      end
   end

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == plng_pkg::FRONT_EMIT |-> CNT_W'(idx_ff) < n_dims)
      else $error("emission index beyond used dimensions");

   a_accept_starts_pass: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == plng_pkg::FRONT_PASS)
      else $error("accepted transaction did not start the stride pass");

   a_advance_after_push: assert property (@(posedge clock) disable iff (reset)
      state_ff == plng_pkg::FRONT_ADVANCE |->
         $past(state_ff) == plng_pkg::FRONT_EMIT && $past(q_push) && $past(last_emit))
      else $error("odometer advanced without the final push");

endmodule

### rtl/plng_queue.sv
module plng_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  plng_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output plng_pkg::entry_type pop_entry,
   output logic                empty
);

   localparam int DEPTH = plng_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   plng_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### rtl/plng_back.sv
module plng_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  plng_pkg::entry_type                 q_entry,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [plng_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [plng_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   logic                                rsp_valid_ff;
   logic [plng_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic [plng_pkg::RSP_USER_W-1:0]     rsp_user_ff;
   logic                                rsp_last_ff;
   logic                                pend_ff;
   plng_pkg::entry_type                 hold_ff;
   logic                                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = out_free && !pend_ff && !q_empty;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // pend_ff: the minus neighbour of the held entry is still to go out
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (out_free) begin
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else if (!q_empty) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (pend_ff) begin
            rsp_data_ff <= {hold_ff.site, hold_ff.nb_minus};
            rsp_user_ff <= {hold_ff.last_site, plng_pkg::DIR_MINUS, hold_ff.dim};
            rsp_last_ff <= hold_ff.last_dim;
         end else if (!q_empty) begin
            rsp_data_ff <= {q_entry.site, q_entry.nb_plus};
            rsp_user_ff <= {q_entry.last_site, plng_pkg::DIR_PLUS, q_entry.dim};
            rsp_last_ff <= 1'b0;
            hold_ff     <= q_entry;
         end
      end
   end

   a_pend_shows_plus: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_tvalid && !rsp_tlast)
      else $error("minus neighbour pending without a plus neighbour on the output");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_tvalid && pend_ff)
      else $error("queue entry popped but not loaded");

   a_last_is_minus: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2] == plng_pkg::DIR_MINUS && !pend_ff)
      else $error("last neighbour of a site is not a minus neighbour");

endmodule

### rtl/periodic_lattice_neighbour_gen.sv
// nearest-neighbour index generator for a periodic n-dimensional lattice
// csr channel: csr_valid/csr_ready with csr_index and csr_data; index 0 sets the
//   dimension count, 1..4 the extents of dimensions 0..3; csr_ready is always high,
//   write only while no request is in flight
// req channel: one transaction per site; req_tdata bit 0 is restart, which puts the
//   walk back to site zero before the neighbours are produced
// rsp channel: 2*n transactions per request (n used dimensions), plus then minus
//   neighbour per dimension in order; tlast marks the final neighbour of the site
// first response: after the stride pass and the finish step, the first entry goes
//   through the queue into the response register; the front takes a new request only
//   after its stride pass (one multiply step per dimension) and one queue push per
//   dimension; the back sends one response per cycle while the receiver is ready
// reset: registers return to two dimensions of extent 16, the walk to site zero,
//   the queue empties
// a stalled receiver holds the response register; the queue fills, the front waits
//   in emission and req_tready stays low until room frees up
module periodic_lattice_neighbour_gen #(
   parameter int MAX_DIMS    = plng_pkg::MAX_DIMS_DEFAULT,
   parameter int EXTENT_BITS = plng_pkg::EXTENT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [plng_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plng_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plng_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] neighbour_index, [63:32] site_index
   output logic [plng_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] dimension, [2] direction, [3] last_site
   output logic [plng_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast    // last_of_site
);

   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;
   plng_pkg::entry_type push_entry;
   plng_pkg::entry_type pop_entry;

   plng_front #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_entry    (push_entry),
      .q_full     (q_full)
   );

   plng_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   plng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/periodic_lattice_neighbour_gen_tb.sv
`timescale 1ns / 1ps

module periodic_lattice_neighbour_gen_tb;

   localparam int MAX_DIMS       = plng_pkg::MAX_DIMS_DEFAULT;
   localparam int EXTENT_BITS    = plng_pkg::EXTENT_BITS_DEFAULT;
   localparam int EXTENT_CAP     = 1 << EXTENT_BITS;
   localparam int TAIL_CYCLES    = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [plng_pkg::FLAT_W-1:0]      neighbour;
      logic [plng_pkg::FLAT_W-1:0]      site;
      logic [plng_pkg::DIM_FIELD_W-1:0] dim;
      logic                             dir;
      logic                             last_of_site;
      logic                             last_site;
   } neighbour_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [plng_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [plng_pkg::CSR_DATA_W-1:0]     csr_data = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [plng_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [plng_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [plng_pkg::RSP_USER_W-1:0]     rsp_tuser;
   logic                                rsp_tlast;

   // lattice model: registers and the walk position
   logic [plng_pkg::NUM_DIMS_W-1:0]  cfg_num_dims = plng_pkg::NUM_DIMS_RESET;
   logic [plng_pkg::EXT_REG_W-1:0]   cfg_extent [plng_pkg::NUM_EXT_REGS] = plng_pkg::EXT_RESET;
   int unsigned                      site_coord [MAX_DIMS] = '{default: 0};

   neighbour_type          nb_expected_q [$];
   int                     mismatch_count = 0;
   int                     quiet_cycles = 0;
   bit                     idle_en = 1'b1;
   int                     hold_len = 0;
   int unsigned            stall_left = 0;

   periodic_lattice_neighbour_gen u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [0] restart
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] neighbour_index, [63:32] site_index
      .rsp_tuser  (rsp_tuser),    // [1:0] dimension, [2] direction, [3] last_site
      .rsp_tlast  (rsp_tlast)     // last_of_site
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned dims_in_use();
      int unsigned n;
      n = cfg_num_dims;
      if (n < 1) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      return n;
   endfunction

   function automatic int unsigned extent_of(int unsigned d);
      int unsigned e;
      if (d >= plng_pkg::NUM_EXT_REGS) return 1;
      e = cfg_extent[d];
      if (e < 1) e = 1;
      if (e > EXTENT_CAP) e = EXTENT_CAP;
      return e;
   endfunction

   function automatic logic [plng_pkg::FLAT_W-1:0] row_major(int unsigned c [MAX_DIMS],
                                                            int unsigned n);
      longint unsigned f;
      f = 0;
      for (int unsigned d = 0; d < n; d++)
         f = f * extent_of(d) + c[d];
      return f[plng_pkg::FLAT_W-1:0];
   endfunction

   // expected neighbours of the current site, then step the odometer
   task automatic predict_site_neighbours(input bit restart);
      int unsigned                 n;
      int unsigned                 e;
      int unsigned                 nb [MAX_DIMS];
      bit                          at_last;
      logic [plng_pkg::FLAT_W-1:0] here;
      neighbour_type               r;
      n = dims_in_use();
      at_last = 1'b1;
      for (int unsigned d = 0; d < MAX_DIMS; d++)
         if (restart || d >= n || site_coord[d] >= extent_of(d)) site_coord[d] = 0;
      for (int unsigned d = 0; d < n; d++)
         if (site_coord[d] != extent_of(d) - 1) at_last = 1'b0;
      here = row_major(site_coord, n);
      for (int unsigned d = 0; d < n; d++) begin
         e = extent_of(d);
         for (int dir = 0; dir < 2; dir++) begin
            nb = site_coord;
            if (dir == plng_pkg::DIR_PLUS) begin
               nb[d] = (site_coord[d] == e - 1) ? 0 : site_coord[d] + 1;
            end else begin
               nb[d] = (site_coord[d] == 0) ? e - 1 : site_coord[d] - 1;
            end
            r.neighbour    = row_major(nb, n);
            r.site         = here;
            r.dim          = d[plng_pkg::DIM_FIELD_W-1:0];
            r.dir          = dir[0];
            r.last_of_site = (d == n - 1) && (dir == plng_pkg::DIR_MINUS);
            r.last_site    = at_last;
            nb_expected_q.push_back(r);
         end
      end
      for (int d = n - 1; d >= 0; d--) begin
         if (site_coord[d] + 1 >= extent_of(d)) begin
            site_coord[d] = 0;
         end else begin
            site_coord[d]++;
            break;
         end
      end
   endtask

   task automatic write_csr(input logic [plng_pkg::CSR_IDX_W-1:0] idx,
                            input logic [plng_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == plng_pkg::CSR_NUM_DIMS) begin
         cfg_num_dims = val[plng_pkg::NUM_DIMS_W-1:0];
      end else if (idx <= plng_pkg::CSR_EXTENT_D3) begin
         cfg_extent[idx - plng_pkg::CSR_EXTENT_D0] = val;
      end
      @(posedge clock);
   endtask

   task automatic set_lattice(input logic [plng_pkg::CSR_DATA_W-1:0] nd, e0, e1, e2, e3);
      write_csr(plng_pkg::CSR_NUM_DIMS, nd);
      write_csr(plng_pkg::CSR_EXTENT_D0, e0);
      write_csr(plng_pkg::CSR_EXTENT_D1, e1);
      write_csr(plng_pkg::CSR_EXTENT_D2, e2);
      write_csr(plng_pkg::CSR_EXTENT_D3, e3);
   endtask

   // valid stays high between back-to-back transactions
   task automatic send_req(input bit restart);
      int unsigned gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(plng_pkg::REQ_DATA_W-1){1'b0}}, restart};
      predict_site_neighbours(restart);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (nb_expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [plng_pkg::CSR_DATA_W-1:0] rand_extent();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return plng_pkg::CSR_DATA_W'(EXTENT_CAP);
         2:       return plng_pkg::CSR_DATA_W'($urandom_range(0, (1 << plng_pkg::CSR_DATA_W) - 1));
         default: return plng_pkg::CSR_DATA_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [plng_pkg::CSR_DATA_W-1:0] rand_num_dims();
      if ($urandom_range(0, 7) == 0) begin
         return plng_pkg::CSR_DATA_W'($urandom_range(0, (1 << plng_pkg::NUM_DIMS_W) - 1));
      end
      return plng_pkg::CSR_DATA_W'($urandom_range(1, MAX_DIMS));
   endfunction

   task automatic test_reset_values();
      send_req(1'b1);
      send_req(1'b0);
      send_req(1'b0);
      drain();
   endtask

   task automatic test_walk_wrap();
      set_lattice(2, 2, 3, 1, 1);
      for (int i = 0; i < 7; i++) send_req(1'b0);
      send_req(1'b1);
      send_req(1'b0);
      drain();
   endtask

   task automatic test_range_clamp();
      // zero dimensions and zero extent act as one
      set_lattice(0, 0, 16, 1, 1);
      send_req(1'b0);
      drain();
      // dimension count above the maximum, full-size extents
      set_lattice(7, EXTENT_CAP, EXTENT_CAP, EXTENT_CAP, EXTENT_CAP);
      send_req(1'b1);
      send_req(1'b0);
      drain();
      set_lattice(MAX_DIMS, (1 << plng_pkg::CSR_DATA_W) - 1, EXTENT_CAP + 1, 3, 1);
      send_req(1'b0);
      drain();
      // indexes past the register list change nothing
      for (int i = 1; i <= 3; i++) begin
         write_csr(plng_pkg::CSR_EXTENT_D3 + i[plng_pkg::CSR_IDX_W-1:0], '1);
      end
      send_req(1'b0);
      drain();
   endtask

   task automatic test_stale_coords();
      set_lattice(2, 4, 4, 1, 1);
      send_req(1'b1);
      for (int i = 0; i < 5; i++) send_req(1'b0);
      drain();
      write_csr(plng_pkg::CSR_EXTENT_D1, 2);
      write_csr(plng_pkg::CSR_EXTENT_D0, 1);
      send_req(1'b0);
      send_req(1'b0);
      drain();
      set_lattice(3, 3, 3, 3, 1);
      send_req(1'b0);
      send_req(1'b0);
      drain();
      write_csr(plng_pkg::CSR_NUM_DIMS, 1);
      send_req(1'b0);
      send_req(1'b0);
      drain();
   endtask

   task automatic test_random_walks();
      int unsigned count;
      for (int phase = 0; phase < 10; phase++) begin
         set_lattice(rand_num_dims(), rand_extent(), rand_extent(), rand_extent(), rand_extent());
         if ($urandom_range(0, 2) == 0) begin
            write_csr(plng_pkg::CSR_IDX_W'($urandom_range(plng_pkg::CSR_EXTENT_D3 + 1,
                                                          (1 << plng_pkg::CSR_IDX_W) - 1)),
                      plng_pkg::CSR_DATA_W'($urandom));
         end
         count = $urandom_range(8, 16);
         for (int i = 0; i < count; i++) send_req($urandom_range(0, 7) == 0);
         drain();
      end
   endtask

   task automatic test_backpressure();
      set_lattice(MAX_DIMS, 2, 2, 2, 2);
      hold_len <= HOLD_CYCLES;
      send_req(1'b1);
      for (int i = 0; i < 11; i++) send_req(1'b0);
      drain();
   endtask

   task automatic test_full_rate();
      idle_en <= 1'b0;
      set_lattice(3, 2, 3, 2, 1);
      for (int i = 0; i < 20; i++) send_req(i == 0);
      drain();
   endtask

   // receiver: random short stalls plus the long hold requested by a test
   always @(posedge clock) begin
      if (hold_len != 0) begin
         stall_left = hold_len;
         hold_len <= 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      end
   end

   function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      neighbour_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (nb_expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual data 0x%0h user 0x%0h",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            e = nb_expected_q.pop_front();
            check_field("neighbour_index", e.neighbour, rsp_tdata[plng_pkg::FLAT_W-1:0]);
            check_field("site_index", e.site,
                        rsp_tdata[2*plng_pkg::FLAT_W-1:plng_pkg::FLAT_W]);
            check_field("dimension", e.dim, rsp_tuser[plng_pkg::DIM_FIELD_W-1:0]);
            check_field("direction", e.dir, rsp_tuser[plng_pkg::DIM_FIELD_W]);
            check_field("last_site", e.last_site, rsp_tuser[plng_pkg::DIM_FIELD_W+1]);
            check_field("last_of_site", e.last_of_site, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("[periodic_lattice_neighbour_gen] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      test_reset_values();
      test_walk_wrap();
      test_range_clamp();
      test_stale_coords();
      test_random_walks();
      test_backpressure();
      test_full_rate();
      if (mismatch_count == 0 && nb_expected_q.size() == 0) begin
         $display("[periodic_lattice_neighbour_gen] OK");
      end else begin
         $display("[periodic_lattice_neighbour_gen] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/plng_pkg.sv
rtl/plng_front.sv
rtl/plng_queue.sv
rtl/plng_back.sv
rtl/periodic_lattice_neighbour_gen.sv
dv/periodic_lattice_neighbour_gen_tb.sv
